// ----- rtl/orbital_coefficient_projection_macros.svh -----
// Assertion macros used by the checker file of the projection block.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef ORBITAL_COEFFICIENT_PROJECTION_MACROS_SVH
`define ORBITAL_COEFFICIENT_PROJECTION_MACROS_SVH

// Checked at every rising edge outside reset.
`define OCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define OCP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ocp_pkg.sv -----
// Package of the orbital coefficient projection block: constants, codes and
// the command and status types between controller and datapath. No dependencies.
`default_nettype none

package ocp_pkg;

	localparam int unsigned OCP_SOURCE_MAX = 256;
	localparam int unsigned OCP_TARGET_MAX = 64;
	localparam int unsigned OCP_COMPONENTS = 5;

	localparam int unsigned LANES      = 5;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned ACC_W      = 48;
	localparam int unsigned FRAC_W     = 24;
	localparam int unsigned PROD_W     = 2 * DATA_W;
	localparam int unsigned SRC_IDX_W  = 8;
	localparam int unsigned TGT_IDX_W  = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned SRC_CNT_W  = 9;
	localparam int unsigned TGT_CNT_W  = 7;

	localparam logic [SRC_CNT_W-1:0] SRC_CNT_RESET = 9'd256;
	localparam logic [TGT_CNT_W-1:0] TGT_CNT_RESET = 7'd64;

	localparam logic [DATA_W-1:0] DATA_POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] DATA_NEG_LIMIT = 32'h8000_0000;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_ELEMENT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_COUNT  = 2'd0,
		CFG_TARGET_COUNT  = 2'd1,
		CFG_GRADIENT_MODE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD
	} ocp_state_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic issue;
		logic out_load;
		logic clear_rows;
	} ocp_cmd_t;

	typedef struct packed {
		logic src_ok;
		logic last_t;
		logic busy;
		logic out_free;
	} ocp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ocp_if.sv -----
// Channel interfaces of the projection block: the input item channel and the
// result channel, each with valid, ready and payload. No dependencies.
`default_nettype none

interface ocp_item_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic        [7:0]  source_index;
	logic        [5:0]  target_index;
	logic signed [31:0] coefficient;
	logic signed [31:0] source_value;
	logic signed [31:0] source_grad_x;
	logic signed [31:0] source_grad_y;
	logic signed [31:0] source_grad_z;
	logic signed [31:0] source_laplacian;
	logic               point_end;

	modport source (output valid, func, source_index, target_index, coefficient,
		source_value, source_grad_x, source_grad_y, source_grad_z, source_laplacian,
		point_end, input ready);
	modport sink (input valid, func, source_index, target_index, coefficient,
		source_value, source_grad_x, source_grad_y, source_grad_z, source_laplacian,
		point_end, output ready);
endinterface

interface ocp_result_if;
	logic               valid;
	logic               ready;
	logic        [5:0]  result_index;
	logic signed [31:0] result_value;
	logic signed [31:0] result_grad_x;
	logic signed [31:0] result_grad_y;
	logic signed [31:0] result_grad_z;
	logic signed [31:0] result_laplacian;
	logic               saturated;
	logic               run_end;

	modport source (output valid, result_index, result_value, result_grad_x,
		result_grad_y, result_grad_z, result_laplacian, saturated, run_end,
		input ready);
	modport sink (input valid, result_index, result_value, result_grad_x,
		result_grad_y, result_grad_z, result_laplacian, saturated, run_end,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/ocp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
`default_nettype none

module ocp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/ocp_ctrl.sv -----
// Controller of the projection block: sequences loads, the per-target
// accumulation sweep, pipeline drain and the result sweep. Uses ocp_pkg.
`default_nettype none

module ocp_ctrl import ocp_pkg::*; #(
	parameter int unsigned TARGET_MAX = OCP_TARGET_MAX,
	localparam int unsigned TGT_W = (TARGET_MAX > 1) ? $clog2(TARGET_MAX) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_func,
	input  wire logic             in_point_end,
	output      logic             in_ready,
	output      logic [TGT_W-1:0] tgt,
	output      ocp_cmd_t         cmd,
	input  wire ocp_sts_t         sts
);

	ocp_state_t       state_q, state_d;
	logic [TGT_W-1:0] tgt_q, tgt_d;
	logic             pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tgt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tgt_q   <= tgt_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		tgt_d    = tgt_q;
		pend_d   = pend_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						pend_d      = in_point_end;
						if (sts.src_ok) begin
							state_d = ST_ACCUM;
						end else if (in_point_end) begin
							state_d = ST_EMIT_RD;
						end
					end
				end
			end
			ST_ACCUM: begin
				cmd.issue = 1'b1;
				if (sts.last_t) begin
					tgt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					tgt_d = tgt_q + TGT_W'(1);
				end
			end
			ST_DRAIN: begin
				// The last accumulator write must land before any row is read again.
				if (!sts.busy) begin
					state_d = pend_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_t) begin
						cmd.clear_rows = 1'b1;
						tgt_d          = '0;
						state_d        = ST_IDLE;
					end else begin
						tgt_d   = tgt_q + TGT_W'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign tgt = tgt_q;

endmodule

`default_nettype wire

// ----- rtl/ocp_datapath.sv -----
// Datapath of the projection block: configuration registers, coefficient and
// accumulator RAMs, five-lane multiply-accumulate pipeline and result register.
// Uses ocp_pkg and ocp_ram.
`default_nettype none

module ocp_datapath import ocp_pkg::*; #(
	parameter int unsigned SOURCE_MAX = OCP_SOURCE_MAX,
	parameter int unsigned TARGET_MAX = OCP_TARGET_MAX,
	parameter int unsigned COMPONENTS = OCP_COMPONENTS,
	localparam int unsigned TGT_W = (TARGET_MAX > 1) ? $clog2(TARGET_MAX) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [SRC_IDX_W-1:0]   in_source_index,
	input  wire logic [TGT_IDX_W-1:0]   in_target_index,
	input  wire logic [DATA_W-1:0]      in_coefficient,
	input  wire logic [DATA_W-1:0]      in_comp [LANES],
	input  wire logic [TGT_W-1:0]       tgt,
	input  wire ocp_cmd_t               cmd,
	output      ocp_sts_t               sts,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic [TGT_IDX_W-1:0]   out_index,
	output      logic [DATA_W-1:0]      out_comp [LANES],
	output      logic                   out_saturated,
	output      logic                   out_run_end
);

	localparam int unsigned SRC_W    = (SOURCE_MAX > 1) ? $clog2(SOURCE_MAX) : 1;
	localparam int unsigned NS_BITS  = $clog2(SOURCE_MAX + 1);
	localparam int unsigned NS_W     = (NS_BITS > SRC_CNT_W) ? NS_BITS : SRC_CNT_W;
	localparam int unsigned ROW_W    = COMPONENTS * ACC_W;
	localparam int unsigned CDEPTH   = SOURCE_MAX * (2 ** TGT_W);
	localparam int unsigned SHIFT_W  = PROD_W - FRAC_W;

	// Configuration registers.
	logic [SRC_CNT_W-1:0] src_cnt_q;
	logic [TGT_CNT_W-1:0] tgt_cnt_q;
	logic                 grad_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q   <= SRC_CNT_RESET;
			tgt_cnt_q   <= TGT_CNT_RESET;
			grad_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE_COUNT:  src_cnt_q   <= cfg_data[SRC_CNT_W-1:0];
				CFG_TARGET_COUNT:  tgt_cnt_q   <= cfg_data[TGT_CNT_W-1:0];
				CFG_GRADIENT_MODE: grad_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Active counts, clamped to 1..max.
	logic [NS_W-1:0]      ns;
	logic [TGT_CNT_W-1:0] nt;
	logic [TGT_W-1:0]     nt_last;
	logic                 load_ok;

	always_comb begin
		if (src_cnt_q == '0) begin
			ns = NS_W'(1);
		end else if (NS_W'(src_cnt_q) > NS_W'(SOURCE_MAX)) begin
			ns = NS_W'(SOURCE_MAX);
		end else begin
			ns = NS_W'(src_cnt_q);
		end
		if (tgt_cnt_q == '0) begin
			nt = TGT_CNT_W'(1);
		end else if (tgt_cnt_q > TGT_CNT_W'(TARGET_MAX)) begin
			nt = TGT_CNT_W'(TARGET_MAX);
		end else begin
			nt = tgt_cnt_q;
		end
	end

	assign nt_last    = TGT_W'(nt - TGT_CNT_W'(1));
	assign sts.src_ok = NS_W'(in_source_index) < ns;
	assign load_ok    = sts.src_ok && (TGT_CNT_W'(in_target_index) < nt);

	// Lane enables: the value lane always, the others in gradient mode.
	logic [COMPONENTS-1:0] lane_en;
	always_comb begin
		for (int c = 0; c < COMPONENTS; c++) begin
			lane_en[c] = (c == 0) || grad_mode_q;
		end
	end

	// Captured element.
	logic        [SRC_W-1:0]  row_q;
	logic signed [DATA_W-1:0] comp_q [COMPONENTS];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= SRC_W'(in_source_index);
			for (int c = 0; c < COMPONENTS; c++) begin
				comp_q[c] <= $signed(in_comp[c]);
			end
		end
	end

	// Coefficient store, addressed by {row, column}.
	logic [DATA_W-1:0] coef_rd;

	ocp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CDEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (cmd.load && load_ok),
		.waddr ({SRC_W'(in_source_index), TGT_W'(in_target_index)}),
		.wdata (in_coefficient),
		.raddr ({row_q, tgt}),
		.rdata (coef_rd)
	);

	// Accumulator rows; a row whose valid bit is clear reads as zero.
	logic [ROW_W-1:0]      acc_rd;
	logic [ROW_W-1:0]      acc_wr;
	logic [TARGET_MAX-1:0] row_vld_q;
	logic                  vld_rd_q;
	logic                  v_s2;
	logic [TGT_W-1:0]      tgt_s2;

	ocp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TARGET_MAX)
	) u_acc_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (tgt_s2),
		.wdata (acc_wr),
		.raddr (tgt),
		.rdata (acc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_rd_q  <= 1'b0;
		end else begin
			vld_rd_q <= row_vld_q[tgt];
			if (cmd.clear_rows) begin
				row_vld_q <= '0;
			end else if (v_s2) begin
				row_vld_q[tgt_s2] <= 1'b1;
			end
		end
	end

	// Stage 1: RAM data arrives; multiply. Stage 2: shift, add, saturate, write.
	logic                     issue_s1;
	logic [TGT_W-1:0]         tgt_s1;
	logic signed [PROD_W-1:0] prod_s2 [COMPONENTS];
	logic [ACC_W-1:0]         acc_s2  [COMPONENTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			v_s2     <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		tgt_s1 <= tgt;
		tgt_s2 <= tgt_s1;
		for (int c = 0; c < COMPONENTS; c++) begin
			prod_s2[c] <= $signed(coef_rd) * comp_q[c];
			acc_s2[c]  <= vld_rd_q ? acc_rd[c*ACC_W +: ACC_W] : '0;
		end
	end

	always_comb begin
		logic [SHIFT_W-1:0] p;
		logic [ACC_W:0]     sum;
		for (int c = 0; c < COMPONENTS; c++) begin
			p   = prod_s2[c][PROD_W-1:FRAC_W];
			sum = {acc_s2[c][ACC_W-1], acc_s2[c]}
				+ {{(ACC_W + 1 - SHIFT_W){p[SHIFT_W-1]}}, p};
			if (!lane_en[c]) begin
				acc_wr[c*ACC_W +: ACC_W] = acc_s2[c];
			end else if (sum[ACC_W] != sum[ACC_W-1]) begin
				// Overflow past 48 bits: clamp to the limit of the true sign.
				acc_wr[c*ACC_W +: ACC_W] = {sum[ACC_W], {(ACC_W - 1){~sum[ACC_W]}}};
			end else begin
				acc_wr[c*ACC_W +: ACC_W] = sum[ACC_W-1:0];
			end
		end
	end

	assign sts.busy    = issue_s1 || v_s2;
	assign sts.last_t  = (tgt == nt_last);
	assign sts.out_free = !out_valid || out_ready;

	// Result register, clipped to 32 bits per component.
	logic [DATA_W-1:0] clip  [LANES];
	logic [LANES-1:0]  clipped;

	always_comb begin
		logic [ACC_W-1:0]      a;
		logic [ACC_W-DATA_W:0] hi;
		for (int c = 0; c < LANES; c++) begin
			a          = '0;
			hi         = '0;
			clip[c]    = '0;
			clipped[c] = 1'b0;
			if (c < COMPONENTS) begin
				if (lane_en[c] && vld_rd_q) begin
					a  = acc_rd[c*ACC_W +: ACC_W];
					hi = a[ACC_W-1:DATA_W-1];
					if ((&hi) || !(|hi)) begin
						clip[c] = a[DATA_W-1:0];
					end else begin
						clip[c]    = a[ACC_W-1] ? DATA_NEG_LIMIT : DATA_POS_LIMIT;
						clipped[c] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_index     <= TGT_IDX_W'(tgt);
			out_saturated <= |clipped;
			out_run_end   <= sts.last_t;
			for (int c = 0; c < LANES; c++) begin
				out_comp[c] <= clip[c];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/orbital_coefficient_projection.sv -----
// Top level of the orbital coefficient projection block: joins the controller
// and the datapath to the item and result channels. Uses ocp_pkg, ocp_if,
// ocp_ctrl and ocp_datapath.
//
// Channel   Direction  Handshake     Carries
// item      in         valid/ready   coefficient loads and source elements
// result    out        valid/ready   one projected target per request
// cfg       in         cfg_we        source_count, target_count, gradient_mode
//
// A source element is swept one target column per cycle through the five-lane
// multiply-add pipeline, followed by a two-stage drain of the accumulator
// write-back. An element with point_end then emits nt results; each takes a
// read state for the registered read of the accumulator RAM and a load state,
// which waits while result is stalled. Reset clears control state and
// accumulator row valid bits at once; there is no clearing pass. Items are
// accepted only between requests; the last result may still wait in the output
// register while the next item is taken.
`default_nettype none

module orbital_coefficient_projection import ocp_pkg::*; #(
	parameter int unsigned SOURCE_MAX = OCP_SOURCE_MAX,
	parameter int unsigned TARGET_MAX = OCP_TARGET_MAX,
	parameter int unsigned COMPONENTS = OCP_COMPONENTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ocp_item_if.sink                   item,
	ocp_result_if.source               result
);

	localparam int unsigned TGT_W = (TARGET_MAX > 1) ? $clog2(TARGET_MAX) : 1;

	ocp_cmd_t          cmd;
	ocp_sts_t          sts;
	logic [TGT_W-1:0]  tgt;
	logic [DATA_W-1:0] in_comp  [LANES];
	logic [DATA_W-1:0] out_comp [LANES];

	assign in_comp[0] = item.source_value;
	assign in_comp[1] = item.source_grad_x;
	assign in_comp[2] = item.source_grad_y;
	assign in_comp[3] = item.source_grad_z;
	assign in_comp[4] = item.source_laplacian;

	ocp_ctrl #(
		.TARGET_MAX (TARGET_MAX)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (item.valid),
		.in_func      (item.func),
		.in_point_end (item.point_end),
		.in_ready     (item.ready),
		.tgt          (tgt),
		.cmd          (cmd),
		.sts          (sts)
	);

	ocp_datapath #(
		.SOURCE_MAX (SOURCE_MAX),
		.TARGET_MAX (TARGET_MAX),
		.COMPONENTS (COMPONENTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_source_index (item.source_index),
		.in_target_index (item.target_index),
		.in_coefficient  (item.coefficient),
		.in_comp         (in_comp),
		.tgt             (tgt),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_index       (result.result_index),
		.out_comp        (out_comp),
		.out_saturated   (result.saturated),
		.out_run_end     (result.run_end)
	);

	assign result.result_value     = out_comp[0];
	assign result.result_grad_x    = out_comp[1];
	assign result.result_grad_y    = out_comp[2];
	assign result.result_grad_z    = out_comp[3];
	assign result.result_laplacian = out_comp[4];

endmodule

`default_nettype wire

// ----- rtl/ocp_checker.sv -----
// Port-level checker of the projection block, bound to the top level.
// Uses ocp_pkg and the assertion macros header.
`default_nettype none

`include "orbital_coefficient_projection_macros.svh"

module ocp_checker import ocp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_func,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  out_index,
	input wire logic [31:0] out_value,
	input wire logic        out_run_end
);

	// A stalled result keeps its payload.
	`OCP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value) && $stable(out_run_end), "result changed while stalled")

	// While a result sweep is unfinished no new item is taken.
	`OCP_ASSERT(a_no_accept_mid_run, out_valid && !out_run_end |-> !in_ready, "item accepted during a result sweep")

	// A coefficient load never starts a result.
	`OCP_ASSERT(a_load_quiet, in_valid && in_ready && in_func == FUNC_LOAD |=> !$rose(out_valid), "result raised after a coefficient load")

	// A coefficient load keeps the controller idle, so the next item can follow at once.
	`OCP_ASSERT(a_load_ready, in_valid && in_ready && in_func == FUNC_LOAD |=> in_ready, "item port not ready after a coefficient load")

	// No result is offered during reset.
	`OCP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind orbital_coefficient_projection ocp_checker u_ocp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_func     (item.func),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_index   (result.result_index),
	.out_value   (result.result_value),
	.out_run_end (result.run_end)
);

`default_nettype wire
